// File: hw/rtl/ufc_pkg.sv
`default_nettype none

package ufc_pkg;

  // field widths of the edge and result transactions
  localparam int unsigned NODE_W = 10;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned EDGE_W = 16;

  // saturation limits and register reset values
  localparam logic [SIZE_W-1:0] SIZE_OUT_MAX   = '1;
  localparam logic [EDGE_W-1:0] EDGE_MAX       = '1;
  localparam logic [SIZE_W-1:0] NODE_COUNT_RST = 11'd1024;

endpackage : ufc_pkg

`default_nettype wire

// File: hw/rtl/ufc_edge_if.sv
`default_nettype none

// edge channel: one undirected edge per transaction
interface ufc_edge_if;
  logic                           valid;
  logic                           ready;
  logic [ufc_pkg::NODE_W-1:0]     node_a;
  logic [ufc_pkg::NODE_W-1:0]     node_b;

  modport source (output valid, output node_a, output node_b, input ready);
  modport sink   (input valid, input node_a, input node_b, output ready);
endinterface : ufc_edge_if

`default_nettype wire

// File: hw/rtl/ufc_result_if.sv
`default_nettype none

// result channel: one result per edge
interface ufc_result_if;
  logic                           valid;
  logic                           ready;
  logic [ufc_pkg::SIZE_W-1:0]     merged_size;
  logic [ufc_pkg::EDGE_W-1:0]     edge_index;
  logic                           all_connected;

  modport source (output valid, output merged_size, output edge_index,
                  output all_connected, input ready);
  modport sink   (input valid, input merged_size, input edge_index,
                  input all_connected, output ready);
endinterface : ufc_result_if

`default_nettype wire

// File: hw/rtl/union_find_connectivity_unit.sv
`default_nettype none

// Union-find engine over MAX_NODES nodes kept in two on-chip memories (parent
// link and set size). Each edge transaction finds the root of both endpoints,
// repoints every node on each walked path straight at its root, then hangs
// the smaller tree under the larger (ties keep the first endpoint's root) and
// returns the merged set size, a saturating one-based edge index and a flag
// that is high when the set holds node_count nodes. The parent memory has one
// read port and one link is followed per cycle; edge_i.ready is low while an
// edge is worked on. A result may wait in the output register while the next
// edge is taken in. After reset a clearing pass initialises both memories,
// during which no edge is taken; node_count may be written at any time but
// only changes the connectivity compare.
module union_find_connectivity_unit #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ufc_pkg::SIZE_W-1:0]    cfg_wdata_i,
  ufc_edge_if.sink                     edge_i,
  ufc_result_if.source                 result_o
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned SW = $clog2(MAX_NODES + 1);
  localparam logic [31:0] MaxIdx = 32'(MAX_NODES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_SZ_A,
    ST_SZ_B,
    ST_DONE
  } state_e;

  // memories
  logic [NW-1:0] parent_mem [MAX_NODES];
  logic [SW-1:0] size_mem   [MAX_NODES];

  logic          pw_en;
  logic [NW-1:0] pw_addr, pw_data, pr_addr, prdata_q;
  logic          sw_en;
  logic [SW-1:0] sw_data, srdata_q;
  logic [NW-1:0] sw_addr, sr_addr;

  // control and result registers
  state_e                      state_q, state_d;
  logic [NW-1:0]               clr_idx_q, clr_idx_d;
  logic [NW-1:0]               a_q, a_d, b_q, b_d, cur_q, cur_d, ra_q, ra_d, rb_q, rb_d;
  logic                        phase_q, phase_d;
  logic [SW-1:0]               sa_q, sa_d, size_q, size_d;
  logic [ufc_pkg::EDGE_W-1:0]  edge_cnt_q, edge_cnt_d;
  logic [ufc_pkg::SIZE_W-1:0]  node_count_q, node_count_d;
  logic                        res_valid_q, res_valid_d;
  logic [ufc_pkg::SIZE_W-1:0]  res_size_q, res_size_d;
  logic [ufc_pkg::EDGE_W-1:0]  res_edge_q, res_edge_d;
  logic                        res_conn_q, res_conn_d;

  logic          edge_acc;
  logic [NW-1:0] a_cl, b_cl, start_node, root_cur;
  logic [31:0]   a_ext, b_ext, size_ext, cnt_ext;
  logic [SW-1:0] size_sum;

  // endpoint clamp to the last node in storage
  assign a_ext = 32'(edge_i.node_a);
  assign b_ext = 32'(edge_i.node_b);
  assign a_cl  = (a_ext > MaxIdx) ? MaxIdx[NW-1:0] : a_ext[NW-1:0];
  assign b_cl  = (b_ext > MaxIdx) ? MaxIdx[NW-1:0] : b_ext[NW-1:0];

  assign edge_i.ready = (state_q == ST_IDLE);
  assign edge_acc     = edge_i.valid && edge_i.ready;

  assign start_node = phase_q ? b_q : a_q;
  assign root_cur   = phase_q ? rb_q : ra_q;
  assign size_sum   = sa_q + srdata_q;
  assign size_ext   = 32'(size_q);
  assign cnt_ext    = 32'(node_count_q);

  // sequencer next state and memory port control
  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    a_d          = a_q;
    b_d          = b_q;
    cur_d        = cur_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    phase_d      = phase_q;
    sa_d         = sa_q;
    size_d       = size_q;
    edge_cnt_d   = edge_cnt_q;
    node_count_d = cfg_we_i ? cfg_wdata_i : node_count_q;
    res_valid_d  = res_valid_q && !result_o.ready;
    res_size_d   = res_size_q;
    res_edge_d   = res_edge_q;
    res_conn_d   = res_conn_q;
    pw_en        = 1'b0;
    pw_addr      = cur_q;
    pw_data      = root_cur;
    pr_addr      = prdata_q;
    sw_en        = 1'b0;
    sw_addr      = ra_q;
    sw_data      = size_sum;
    sr_addr      = ra_q;

    case (state_q)
      // reset pass: each node its own root, every set of size one
      ST_CLEAR: begin
        pw_en   = 1'b1;
        pw_addr = clr_idx_q;
        pw_data = clr_idx_q;
        sw_en   = 1'b1;
        sw_addr = clr_idx_q;
        sw_data = SW'(1);
        if (32'(clr_idx_q) == MaxIdx) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + NW'(1);
        end
      end

      // take an edge and start walking from the first endpoint
      ST_IDLE: begin
        pr_addr = a_cl;
        if (edge_acc) begin
          a_d     = a_cl;
          b_d     = b_cl;
          cur_d   = a_cl;
          phase_d = 1'b0;
          if (edge_cnt_q != ufc_pkg::EDGE_MAX) begin
            edge_cnt_d = edge_cnt_q + ufc_pkg::EDGE_W'(1);
          end
          state_d = ST_FIND;
        end
      end

      // first pass: follow links until a node points at itself
      ST_FIND: begin
        if (prdata_q == cur_q) begin
          if (phase_q) begin
            rb_d = cur_q;
          end else begin
            ra_d = cur_q;
          end
          cur_d   = start_node;
          pr_addr = start_node;
          state_d = ST_COMP;
        end else begin
          cur_d   = prdata_q;
          pr_addr = prdata_q;
        end
      end

      // second pass: repoint each visited node at the root
      ST_COMP: begin
        if (cur_q == root_cur) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            cur_d   = b_q;
            pr_addr = b_q;
            state_d = ST_FIND;
          end else begin
            sr_addr = ra_q;
            state_d = ST_SZ_A;
          end
        end else begin
          pw_en   = 1'b1;
          pw_addr = cur_q;
          pw_data = root_cur;
          cur_d   = prdata_q;
          pr_addr = prdata_q;
        end
      end

      // size of the first root arrives, fetch the second
      ST_SZ_A: begin
        sa_d    = srdata_q;
        sr_addr = rb_q;
        state_d = ST_SZ_B;
      end

      // union by size, ties keep the first root
      ST_SZ_B: begin
        if (ra_q == rb_q) begin
          size_d = sa_q;
        end else begin
          pw_en   = 1'b1;
          sw_en   = 1'b1;
          sw_data = size_sum;
          size_d  = size_sum;
          if (sa_q < srdata_q) begin
            pw_addr = ra_q;
            pw_data = rb_q;
            sw_addr = rb_q;
          end else begin
            pw_addr = rb_q;
            pw_data = ra_q;
            sw_addr = ra_q;
          end
        end
        state_d = ST_DONE;
      end

      // load the output register once it is free
      ST_DONE: begin
        if (!res_valid_q || result_o.ready) begin
          res_valid_d = 1'b1;
          res_size_d  = (size_ext > 32'(ufc_pkg::SIZE_OUT_MAX)) ?
                        ufc_pkg::SIZE_OUT_MAX : size_ext[ufc_pkg::SIZE_W-1:0];
          res_edge_d  = edge_cnt_q;
          res_conn_d  = (size_ext == cnt_ext);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      phase_q      <= 1'b0;
      edge_cnt_q   <= '0;
      node_count_q <= ufc_pkg::NODE_COUNT_RST;
      res_valid_q  <= 1'b0;
      res_size_q   <= '0;
      res_edge_q   <= '0;
      res_conn_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      phase_q      <= phase_d;
      edge_cnt_q   <= edge_cnt_d;
      node_count_q <= node_count_d;
      res_valid_q  <= res_valid_d;
      res_size_q   <= res_size_d;
      res_edge_q   <= res_edge_d;
      res_conn_q   <= res_conn_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    cur_q      <= cur_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    sa_q       <= sa_d;
    size_q     <= size_d;
  end

  // parent link memory
  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      parent_mem[pw_addr] <= pw_data;
    end
    prdata_q <= parent_mem[pr_addr];
  end

  // set size memory
  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      size_mem[sw_addr] <= sw_data;
    end
    srdata_q <= size_mem[sr_addr];
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.merged_size   = res_size_q;
  assign result_o.edge_index    = res_edge_q;
  assign result_o.all_connected = res_conn_q;

  // an accepted edge keeps the block busy for at least the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_acc |=> !edge_i.ready)
    else $error("edge taken again right after a transaction");

  // path compression never turns a node into its own parent
  a_comp_no_self_link : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && pw_en) |-> (pw_addr != pw_data))
    else $error("compression write creates a self link");

  // a fresh result always carries a counted edge and a non-empty set
  a_result_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> (result_o.edge_index != '0 && result_o.merged_size != '0))
    else $error("result with zero edge index or empty set");

endmodule : union_find_connectivity_unit

`default_nettype wire

// File: bench/union_find_connectivity_unit_tb.sv
`timescale 1ns / 1ps

module union_find_connectivity_unit_tb;

  localparam int unsigned MAX_NODES     = 1024;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLDOFF_LEN   = 500;
  localparam int unsigned RANDOM_EDGES  = 690;

  typedef struct packed {
    logic [ufc_pkg::NODE_W-1:0] node_a;
    logic [ufc_pkg::NODE_W-1:0] node_b;
  } edge_item_t;

  typedef struct packed {
    logic [ufc_pkg::SIZE_W-1:0] merged_size;
    logic [ufc_pkg::EDGE_W-1:0] edge_index;
    logic                       all_connected;
  } set_report_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [ufc_pkg::SIZE_W-1:0] cfg_wdata;

  ufc_edge_if   edge_if();
  ufc_result_if result_if();

  union_find_connectivity_unit #(
    .MAX_NODES(MAX_NODES)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .edge_i     (edge_if),
    .result_o   (result_if)
  );

  // shadow forest and register
  logic [ufc_pkg::NODE_W-1:0] forest_parent [MAX_NODES];
  int unsigned                tree_size [MAX_NODES];
  logic [ufc_pkg::EDGE_W-1:0] edge_count;
  logic [ufc_pkg::SIZE_W-1:0] node_count_cfg;

  edge_item_t  edges_to_send [$];
  set_report_t set_reports_due [$];
  int unsigned edges_issued  = 0;
  int unsigned results_seen  = 0;
  int unsigned fail_count    = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  logic [7:0]  stall_pattern = 8'hFF;
  int unsigned pattern_left  = 0;
  logic        long_hold;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // reset and initial drive
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    long_hold           = 1'b0;
    edge_if.valid       = 1'b0;
    edge_if.node_a      = '0;
    edge_if.node_b      = '0;
    result_if.ready     = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      forest_parent[i] = i[ufc_pkg::NODE_W-1:0];
      tree_size[i]     = 1;
    end
    edge_count     = '0;
    node_count_cfg = ufc_pkg::NODE_COUNT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // two-pass find: locate the root, then point the whole path at it
  function automatic logic [ufc_pkg::NODE_W-1:0] find_and_compress(
    input logic [ufc_pkg::NODE_W-1:0] node);
    logic [ufc_pkg::NODE_W-1:0] root;
    logic [ufc_pkg::NODE_W-1:0] cur;
    logic [ufc_pkg::NODE_W-1:0] nxt;
    int unsigned                steps;
    root  = node;
    steps = 0;
    while (forest_parent[root] != root && steps < MAX_NODES) begin
      root = forest_parent[root];
      steps++;
    end
    cur   = node;
    steps = 0;
    while (cur != root && steps < MAX_NODES) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
      steps++;
    end
    return root;
  endfunction

  // union by size, ties keep the first endpoint's root
  function automatic set_report_t merge_edge(input logic [ufc_pkg::NODE_W-1:0] a,
                                             input logic [ufc_pkg::NODE_W-1:0] b);
    logic [ufc_pkg::NODE_W-1:0] ra;
    logic [ufc_pkg::NODE_W-1:0] rb;
    logic [ufc_pkg::NODE_W-1:0] swap;
    int unsigned                total;
    set_report_t                rep;
    if (edge_count != ufc_pkg::EDGE_MAX) edge_count++;
    ra = find_and_compress(a);
    rb = find_and_compress(b);
    if (ra != rb) begin
      if (tree_size[ra] < tree_size[rb]) begin
        swap = ra;
        ra   = rb;
        rb   = swap;
      end
      forest_parent[rb] = ra;
      tree_size[ra]     = tree_size[ra] + tree_size[rb];
    end
    total             = tree_size[ra];
    rep.merged_size   = (total > ufc_pkg::SIZE_OUT_MAX) ? ufc_pkg::SIZE_OUT_MAX :
                        total[ufc_pkg::SIZE_W-1:0];
    rep.edge_index    = edge_count;
    rep.all_connected = (total == node_count_cfg);
    return rep;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch @%0t: %s", $time, msg);
  endtask

  function automatic void queue_edge(input int unsigned a, input int unsigned b);
    edge_item_t it;
    it.node_a = a[ufc_pkg::NODE_W-1:0];
    it.node_b = b[ufc_pkg::NODE_W-1:0];
    edges_to_send.push_back(it);
    edges_issued++;
  endfunction

  // every issued edge has reported, then let the engine settle
  task automatic wait_for_drain();
    do @(posedge clk);
    while (results_seen != edges_issued);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [ufc_pkg::SIZE_W-1:0] value);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    node_count_cfg = value;
  endtask

  // edge driver: bursts with random gaps, predicts on each transaction
  always @(posedge clk) begin : edge_driver
    edge_item_t nxt;
    if (!rst_n) begin
      edge_if.valid <= 1'b0;
    end else begin
      if (edge_if.valid && edge_if.ready) begin
        set_reports_due.push_back(merge_edge(edge_if.node_a, edge_if.node_b));
      end
      if (!edge_if.valid || edge_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          edge_if.valid <= 1'b0;
        end else if (edges_to_send.size() != 0) begin
          nxt = edges_to_send.pop_front();
          edge_if.valid  <= 1'b1;
          edge_if.node_a <= nxt.node_a;
          edge_if.node_b <= nxt.node_b;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          edge_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk) begin : result_monitor
    set_report_t want;
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (set_reports_due.size() == 0) begin
          note_failure($sformatf("unexpected result size %0d index %0d flag %0b",
                                 result_if.merged_size, result_if.edge_index,
                                 result_if.all_connected));
        end else begin
          want = set_reports_due.pop_front();
          if (result_if.merged_size !== want.merged_size)
            note_failure($sformatf("merged_size exp %0d got %0d (edge %0d)",
                                   want.merged_size, result_if.merged_size, want.edge_index));
          if (result_if.edge_index !== want.edge_index)
            note_failure($sformatf("edge_index exp %0d got %0d",
                                   want.edge_index, result_if.edge_index));
          if (result_if.all_connected !== want.all_connected)
            note_failure($sformatf("all_connected exp %0b got %0b (edge %0d)",
                                   want.all_connected, result_if.all_connected,
                                   want.edge_index));
        end
      end
      if (pattern_left == 0) begin
        pattern_left  = $urandom_range(20, 200);
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      end else begin
        pattern_left--;
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
      result_if.ready <= !long_hold && stall_pattern[0];
    end
  end

  // long receiver hold-off while edges are still on offer
  initial begin : long_holdoff
    while (!(results_seen >= 150 && edges_to_send.size() >= 4)) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLDOFF_LEN) @(posedge clk);
    long_hold <= 1'b0;
  end

  // run limit
  initial begin : watchdog
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus phases
  initial begin : stimulus
    int unsigned cursor;
    int unsigned w;
    int unsigned n;
    int unsigned pick;
    int unsigned queued;
    logic [ufc_pkg::NODE_W-1:0] walk;
    int unsigned steps;

    @(posedge rst_n);

    // single-node sets, extremes, self loops, repeats and a tie
    write_node_count(11'd1);
    queue_edge(5, 5);
    queue_edge(0, 1023);
    queue_edge(1023, 0);
    queue_edge(0, 0);
    queue_edge(1, 2);
    queue_edge(3, 4);
    queue_edge(2, 4);
    queue_edge(4, 2);

    // full set of four, then endpoints beyond node_count
    write_node_count(11'd4);
    queue_edge(1, 1);
    queue_edge(1000, 3);
    queue_edge(3, 1000);

    // zero and all-ones register values never match
    write_node_count(11'd0);
    queue_edge(6, 6);
    write_node_count(11'd2047);
    queue_edge(6, 7);
    queue_edge(0, 5);
    queue_edge(7, 5);
    queue_edge(1, 7);

    // random windows of fresh nodes, node_count set to the window width
    cursor = 8;
    queued = 0;
    while (queued < RANDOM_EDGES) begin
      w = $urandom_range(2, 40);
      if (cursor + w > 999) break;
      write_node_count(w[ufc_pkg::SIZE_W-1:0]);
      n = 2 * w + $urandom_range(0, 12);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)
          queue_edge($urandom_range(cursor, cursor + w - 1),
                     $urandom_range(cursor, cursor + w - 1));
        else if (pick < 94) begin
          steps = $urandom_range(cursor, cursor + w - 1);
          queue_edge(steps, steps);
        end else
          queue_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      queued += n;
      cursor += w;
    end

    // node_count matching the set of node 0, then edges inside it
    wait_for_drain();
    walk  = '0;
    steps = 0;
    while (forest_parent[walk] != walk && steps < MAX_NODES) begin
      walk = forest_parent[walk];
      steps++;
    end
    write_node_count((tree_size[walk] > ufc_pkg::SIZE_OUT_MAX) ? ufc_pkg::SIZE_OUT_MAX :
                     tree_size[walk][ufc_pkg::SIZE_W-1:0]);
    queue_edge(0, 0);
    queue_edge(1023, 0);

    // back to the reset value, noise across the whole node range
    write_node_count(ufc_pkg::NODE_COUNT_RST);
    for (int k = 0; k < 60; k++) queue_edge($urandom_range(0, 1023), $urandom_range(0, 1023));

    wait_for_drain();
    if (fail_count == 0 && set_reports_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
